// ===== sv/psg_pkg.sv =====
// ----------------------------------------------------------------------------
// psg_pkg
// Shared constants, note increments, quarter-wave sine table and the
// controller/datapath command and status types.
// ----------------------------------------------------------------------------
package psg_pkg;

  // Fixed formats
  localparam int PHASE_BITS      = 32;
  localparam int SINE_TABLE_BITS = 10;
  localparam int QB              = SINE_TABLE_BITS - 2;
  localparam int QUARTER         = 1 << QB;
  localparam int NUM_NOTES       = 20;
  localparam int GATE_W          = 20;
  localparam int SAMPLE_W        = 16;
  localparam int GAIN_W          = 15;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 15'd3200;

  localparam logic [63:0] RATE_DEN    = 64'd441000000;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  // Note frequencies C4 upward by semitone, in units of 1e-4 Hz
  typedef logic [0:NUM_NOTES-1][31:0] freq_tab_t;
  localparam freq_tab_t NOTE_FREQ = '{
    32'd2616256, 32'd2771826, 32'd2936648, 32'd3111270, 32'd3296276,
    32'd3492282, 32'd3699944, 32'd3919954, 32'd4153047, 32'd4400000,
    32'd4661638, 32'd4938833, 32'd5232511, 32'd5543653, 32'd5872950,
    32'd6222540, 32'd6592551, 32'd6984565, 32'd7399888, 32'd7839909
  };

  // Phase increment: f * 2^PHASE_BITS / sample rate, rounded half up
  function automatic logic [PHASE_BITS-1:0] note_inc(input logic [63:0] f);
    logic [63:0] q;
    q = (f << (PHASE_BITS + 1)) / RATE_DEN;
    return PHASE_BITS'((q + 64'd1) >> 1);
  endfunction

  typedef logic [0:NUM_NOTES-1][PHASE_BITS-1:0] inc_tab_t;

  function automatic inc_tab_t build_inc_tab();
    inc_tab_t tab;
    for (int n = 0; n < NUM_NOTES; n++) begin
      tab[n] = note_inc(64'(NOTE_FREQ[n]));
    end
    return tab;
  endfunction

  localparam inc_tab_t NOTE_INC = build_inc_tab();

  // First-quadrant sine by Taylor series in Q30, scaled to 2^15
  function automatic logic [14:0] quarter_sine(input logic [63:0] j);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    x  = (HALF_PI_Q30 * j) >> QB;
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd210;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd156;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd110;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    v  = (s + (64'd1 << 14)) >> 15;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[14:0];
  endfunction

  typedef logic [0:QUARTER-1][14:0] qtab_t;

  function automatic qtab_t build_qtab();
    qtab_t tab;
    for (int j = 0; j < QUARTER; j++) begin
      tab[j] = quarter_sine(64'(j));
    end
    return tab;
  endfunction

  localparam qtab_t       QTAB  = build_qtab();
  // Peak value, reached by the mirrored quadrant at offset zero
  localparam logic [14:0] QPEAK = quarter_sine(64'(QUARTER));

  // Controller to datapath commands
  typedef struct packed {
    logic start;  // capture the input word, clear the sum
    logic rd;     // read the phase of the addressed voice
    logic mul;    // scale the sum by the gain
    logic emit;   // load the output register
  } psg_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_busy;  // output register holds a word not taken this cycle
  } psg_stat_t;

endpackage

// ===== sv/polyphonic_sine_tone_generator.sv =====
// ----------------------------------------------------------------------------
// polyphonic_sine_tone_generator
// Additive sine synthesiser: one phase accumulator per voice, one mixed,
// scaled and saturated sample per tick word.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------
//   in      | input     | in_valid / in_ready  | voice_gates, end_of_block
//   out     | output    | out_valid / out_ready| sample, clipped, block_end
//   cfg     | input     | cfg_valid / cfg_ready| cfg_data (output gain)
//
// One tick word runs through an accept step, then the voices one per cycle
// through the phase memory read port and sine lookup, a pipeline drain,
// a multiply step and an output step. Reset is synchronous; it zeroes every
// phase and loads the default gain. A stalled output holds its word; the
// next tick word is taken meanwhile and its result waits in the output
// state until the register frees.
// ----------------------------------------------------------------------------
module polyphonic_sine_tone_generator import psg_pkg::*; #(
  parameter int VOICES = 20
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [GATE_W-1:0]          voice_gates,
  input  logic                       end_of_block,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] sample,
  output logic                       clipped,
  output logic                       block_end,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [GAIN_W-1:0]          cfg_data
);

  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;

  psg_cmd_t      cmd;
  psg_stat_t     stat;
  logic [VW-1:0] voice;

  // Gain writes are always taken
  assign cfg_ready = 1'b1;

  psg_ctrl #(
    .VOICES (VOICES),
    .VW     (VW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd),
    .voice    (voice)
  );

  psg_datapath #(
    .VOICES (VOICES),
    .VW     (VW)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .voice        (voice),
    .stat         (stat),
    .voice_gates  (voice_gates),
    .end_of_block (end_of_block),
    .cfg_data     (cfg_data),
    .cfg_wr       (cfg_valid && cfg_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sample       (sample),
    .clipped      (clipped),
    .block_end    (block_end)
  );

endmodule

// ===== sv/psg_ctrl.sv =====
// ----------------------------------------------------------------------------
// psg_ctrl
// Sequencer: sweeps the voices through the datapath, then scales and
// hands the mixed sample to the output register.
// ----------------------------------------------------------------------------
module psg_ctrl import psg_pkg::*; #(
  parameter int VOICES = 20,
  parameter int VW     = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  psg_stat_t        stat,
  output psg_cmd_t         cmd,
  output logic [VW-1:0]    voice
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWEEP,
    S_DRAIN,
    S_MUL,
    S_EMIT
  } state_t;

  state_t state;

  // Decode commands from the state
  assign in_ready  = (state == S_IDLE);
  assign cmd.start = (state == S_IDLE) && in_valid;
  assign cmd.rd    = (state == S_SWEEP);
  assign cmd.mul   = (state == S_MUL);
  assign cmd.emit  = (state == S_EMIT) && !stat.out_busy;

  // Advance the sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      voice <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_SWEEP;
            voice <= '0;
          end
        end
        S_SWEEP: begin
          if (voice == VW'(VOICES - 1)) begin
            state <= S_DRAIN;
            voice <= '0;
          end else begin
            voice <= voice + VW'(1);
          end
        end
        S_DRAIN: begin
          // wait for the last two pipeline stages to settle
          if (voice == VW'(1)) begin
            state <= S_MUL;
          end else begin
            voice <= VW'(1);
          end
        end
        S_MUL: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!stat.out_busy) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/psg_datapath.sv =====
// ----------------------------------------------------------------------------
// psg_datapath
// Phase memory, shared phase adder and sine lookup, mix accumulator,
// gain multiplier, truncation and saturation, and the output register.
// ----------------------------------------------------------------------------
module psg_datapath import psg_pkg::*; #(
  parameter int VOICES = 20,
  parameter int VW     = 5
) (
  input  logic                       clk,
  input  logic                       rst,
  input  psg_cmd_t                   cmd,
  input  logic [VW-1:0]              voice,
  output psg_stat_t                  stat,
  input  logic [GATE_W-1:0]          voice_gates,
  input  logic                       end_of_block,
  input  logic [GAIN_W-1:0]          cfg_data,
  input  logic                       cfg_wr,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] sample,
  output logic                       clipped,
  output logic                       block_end
);

  localparam int SUM_W = SAMPLE_W + 1 + $clog2(VOICES);
  localparam int PW    = SUM_W + GAIN_W + 1;
  localparam int QW    = PW - 15;
  localparam int GW    = (VOICES > GATE_W) ? VOICES : GATE_W;

  localparam logic signed [QW-1:0] SAT_MAX = QW'(32767);
  localparam logic signed [QW-1:0] SAT_MIN = -QW'(32768);

  typedef logic [0:VOICES-1][PHASE_BITS-1:0] vinc_t;

  // Per-voice increments; voices without a note stand still
  function automatic vinc_t build_vinc();
    vinc_t tab;
    for (int n = 0; n < VOICES; n++) begin
      if (n < NUM_NOTES) begin
        tab[n] = NOTE_INC[n];
      end else begin
        tab[n] = '0;
      end
    end
    return tab;
  endfunction

  localparam vinc_t INC_TAB = build_vinc();

  logic [GAIN_W-1:0]           gain;
  logic [VOICES-1:0]           gate_q;
  logic                        eob_q;
  logic [GW-1:0]               gates_ext;

  logic [PHASE_BITS-1:0]       phase_mem [VOICES];
  logic [VOICES-1:0]           ph_valid;
  logic [PHASE_BITS-1:0]       rd_data;
  logic                        rd_ok;
  logic                        s2_valid;
  logic [VW-1:0]               vidx2;

  logic [PHASE_BITS-1:0]       phase_cur;
  logic [PHASE_BITS-1:0]       phase_next;
  logic [1:0]                  quad;
  logic [QB-1:0]               qoff;
  logic [QB-1:0]               qmir;
  logic [14:0]                 mag;
  logic signed [SAMPLE_W-1:0]  sval;

  logic                        s3_valid;
  logic signed [SAMPLE_W-1:0]  sine3;
  logic signed [SUM_W-1:0]     sum;
  logic signed [PW-1:0]        prod;
  logic signed [PW-1:0]        prod_adj;
  logic signed [QW-1:0]        quot;
  logic signed [SAMPLE_W-1:0]  sample_next;
  logic                        clipped_next;

  assign stat.out_busy = out_valid && !out_ready;

  // Gain register
  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GAIN_RESET;
    end else if (cfg_wr) begin
      gain <= cfg_data;
    end
  end

  // Capture the input word
  assign gates_ext = GW'(voice_gates);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      gate_q <= gates_ext[VOICES-1:0];
      eob_q  <= end_of_block;
    end
  end

  // Phase memory: read in the sweep, write back in the following cycle
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_data <= phase_mem[voice];
    end
    if (s2_valid) begin
      phase_mem[vidx2] <= phase_next;
    end
  end

  // Entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      ph_valid <= '0;
      rd_ok    <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      rd_ok    <= ph_valid[voice];
      s2_valid <= cmd.rd;
      s3_valid <= s2_valid;
      if (s2_valid) begin
        ph_valid[vidx2] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    vidx2 <= voice;
  end

  // Sine lookup and phase advance for the voice in stage two
  always_comb begin
    phase_cur  = rd_ok ? rd_data : '0;
    quad       = phase_cur[PHASE_BITS-1 -: 2];
    qoff       = phase_cur[PHASE_BITS-3 -: QB];
    qmir       = QB'(0) - qoff;
    if (quad[0]) begin
      mag = (qoff == '0) ? QPEAK : QTAB[qmir];
    end else begin
      mag = QTAB[qoff];
    end
    sval       = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    phase_next = phase_cur + (gate_q[vidx2] ? INC_TAB[vidx2] : '0);
  end

  always_ff @(posedge clk) begin
    sine3 <= sval;
  end

  // Mix accumulator
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      sum <= '0;
    end else if (s3_valid) begin
      sum <= sum + SUM_W'(sine3);
    end
  end

  // Scale by the gain
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= PW'(sum) * PW'($signed({1'b0, gain}));
    end
  end

  // Truncate toward zero, then saturate
  always_comb begin
    prod_adj     = prod + (prod[PW-1] ? PW'(32767) : PW'(0));
    quot         = $signed(prod_adj[PW-1:15]);
    clipped_next = 1'b0;
    if (quot > SAT_MAX) begin
      sample_next  = 16'sh7fff;
      clipped_next = 1'b1;
    end else if (quot < SAT_MIN) begin
      sample_next  = -16'sh8000;
      clipped_next = 1'b1;
    end else begin
      sample_next  = quot[SAMPLE_W-1:0];
    end
  end

  // Output register: hold the word until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      sample    <= sample_next;
      clipped   <= clipped_next;
      block_end <= eob_q;
    end
  end

endmodule

// ===== sv/psg_checker.sv =====
// ----------------------------------------------------------------------------
// psg_checker
// Port-level checks on the tone generator, bound to the top level.
// ----------------------------------------------------------------------------
module psg_checker import psg_pkg::*; (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [SAMPLE_W-1:0] sample,
  input logic                       clipped,
  input logic                       block_end
);

  // Reset leaves the block empty and ready
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not empty after reset");

  // A taken tick word keeps the input closed for the sweep
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("input reopened during sweep");

  // A stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample) &&
      $stable(clipped) && $stable(block_end))
    else $error("output word changed under stall");

  // Clipping only ever reports a rail value
  a_clip_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && clipped |-> (sample == 16'sh7fff) || (sample == -16'sh8000))
    else $error("clipped sample not at a rail");

endmodule

bind polyphonic_sine_tone_generator psg_checker u_psg_checker (.*);

// ===== verif/tb_polyphonic_sine_tone_generator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_polyphonic_sine_tone_generator
// Drives tick words with random gate patterns and buffer-end marks into the
// tone generator and checks every mixed sample, clip flag and buffer-end echo
// against a cycle-free prediction that keeps its own voice phases, sine
// table and gain. The gain is rewritten between phases while the block is
// idle. Sender and receiver idle at random, and one long output stall fills
// the block.
// ----------------------------------------------------------------------------
module tb_polyphonic_sine_tone_generator;
  import psg_pkg::*;

  localparam int VOICE_COUNT = 20;
  localparam int LUT_SIZE    = 1 << SINE_TABLE_BITS;
  localparam int DRAIN_WAIT  = 40;
  localparam int LONG_HOLD   = 600;
  localparam int CHUNK_TICKS = 110;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [GAIN_W-1:0] GAIN_MAX = '1;
  localparam logic [GATE_W-1:0] ALL_GATES = '1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       clipped;
    logic                       block_end;
  } mix_word_t;

  // Predicts the mixed sample of each tick and holds those not yet seen
  class sample_tracker;
    logic [PHASE_BITS-1:0] phase_acc [VOICE_COUNT];
    logic [PHASE_BITS-1:0] phase_step [VOICE_COUNT];
    int                    sine_lut [LUT_SIZE];
    logic [GAIN_W-1:0]     gain;
    mix_word_t             pending [$];
    int                    errors;
    int                    checked;
    int                    clips;
    int                    buffer_ends;

    function new();
      logic [63:0] note_hz [VOICE_COUNT];
      logic [63:0] q;
      int          v;
      note_hz = '{
        64'd2616256, 64'd2771826, 64'd2936648, 64'd3111270, 64'd3296276,
        64'd3492282, 64'd3699944, 64'd3919954, 64'd4153047, 64'd4400000,
        64'd4661638, 64'd4938833, 64'd5232511, 64'd5543653, 64'd5872950,
        64'd6222540, 64'd6592551, 64'd6984565, 64'd7399888, 64'd7839909
      };
      // Per-note phase step, rounded half up
      for (int n = 0; n < VOICE_COUNT; n++) begin
        q = (note_hz[n] << (PHASE_BITS + 1)) / 64'd441000000;
        phase_step[n] = PHASE_BITS'((q + 64'd1) >> 1);
        phase_acc[n] = '0;
      end
      // Full-wave table mirrored from the first quadrant
      for (int i = 0; i < LUT_SIZE; i++) begin
        if (i & (LUT_SIZE / 4)) begin
          v = quarter_amp(LUT_SIZE / 4 - (i % (LUT_SIZE / 4)));
        end else begin
          v = quarter_amp(i % (LUT_SIZE / 4));
        end
        sine_lut[i] = (i & (LUT_SIZE / 2)) ? -v : v;
      end
      gain = 15'd3200;
      errors = 0;
      checked = 0;
      clips = 0;
      buffer_ends = 0;
    endfunction

    // First-quadrant amplitude from a Taylor series in Q30
    function int quarter_amp(int j);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] v;
      logic [63:0] k;
      x  = (64'd1686629713 * 64'(j)) / 64'(LUT_SIZE / 4);
      x2 = (x * x) >> 30;
      t  = 64'd1 << 30;
      for (k = 64'd14; k >= 64'd2; k = k - 64'd2) begin
        t = (64'd1 << 30) - ((x2 * t) >> 30) / (k * (k + 64'd1));
      end
      s = (x * t) >> 30;
      v = (s + (64'd1 << 14)) >> 15;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      return int'(v);
    endfunction

    // Mix the current phases, then advance the gated voices
    function void take_tick(logic [GATE_W-1:0] gates, logic eob);
      longint    sum;
      longint    scaled;
      mix_word_t w;
      sum = 0;
      w.clipped = 1'b0;
      for (int n = 0; n < VOICE_COUNT; n++) begin
        sum += sine_lut[phase_acc[n][PHASE_BITS-1 -: SINE_TABLE_BITS]];
      end
      scaled = (sum * longint'(gain)) / 32768;
      if (scaled > 32767) begin
        scaled = 32767;
        w.clipped = 1'b1;
      end else if (scaled < -32768) begin
        scaled = -32768;
        w.clipped = 1'b1;
      end
      for (int n = 0; n < VOICE_COUNT; n++) begin
        if (gates[n]) begin
          phase_acc[n] = phase_acc[n] + phase_step[n];
        end
      end
      w.sample = scaled[SAMPLE_W-1:0];
      w.block_end = eob;
      pending.push_back(w);
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH word %0d: %s", checked, what);
      errors++;
    endtask

    // Compare one output word with the oldest prediction
    task check_sample(mix_word_t got);
      mix_word_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected sample %0d", got.sample));
      end else begin
        want = pending.pop_front();
        if (got.sample !== want.sample) begin
          report_mismatch($sformatf("sample %0d, want %0d", got.sample, want.sample));
        end
        if (got.clipped !== want.clipped) begin
          report_mismatch($sformatf("clipped %b, want %b", got.clipped, want.clipped));
        end
        if (got.block_end !== want.block_end) begin
          report_mismatch($sformatf("block_end %b, want %b", got.block_end, want.block_end));
        end
        clips += want.clipped;
        buffer_ends += want.block_end;
      end
      checked++;
    endtask
  endclass

  logic                       clk;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [GATE_W-1:0]          voice_gates = '0;
  logic                       end_of_block = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       clipped;
  logic                       block_end;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [GAIN_W-1:0]          cfg_data = '0;

  sample_tracker tracker = new();
  int            tx_idle_pct = 0;
  int            rx_idle_pct = 0;
  bit            hold_request = 1'b0;
  int            gain_writes = 0;
  int            cycles = 0;

  polyphonic_sine_tone_generator dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .voice_gates  (voice_gates),
    .end_of_block (end_of_block),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sample       (sample),
    .clipped      (clipped),
    .block_end    (block_end),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Watch the three channels at each edge
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        tracker.gain = cfg_data;
      end
      if (in_valid && in_ready) begin
        tracker.take_tick(voice_gates, end_of_block);
      end
      if (out_valid && out_ready) begin
        tracker.check_sample('{sample, clipped, block_end});
      end
    end
  end

  // Receiver: random back-pressure, or one long stall on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Offer one tick word, idling first at the current rate
  task automatic send_tick(logic [GATE_W-1:0] gates, logic eob);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    voice_gates <= gates;
    end_of_block <= eob;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and let every outstanding word come back
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_gain(logic [GAIN_W-1:0] g);
    cfg_valid <= 1'b1;
    cfg_data <= g;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    gain_writes++;
    repeat (2) @(posedge clk);
  endtask

  initial begin
    logic [GATE_W-1:0] chord;
    logic [GATE_W-1:0] gates;
    int                c;
    int                pick;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset gain: silence at phase zero, then full, sparse and split chords
    send_tick('0, 1'b0);
    send_tick(ALL_GATES, 1'b1);
    send_tick(ALL_GATES, 1'b0);
    send_tick(20'h00001, 1'b0);
    send_tick(20'h80000, 1'b1);
    send_tick(20'hAAAAA, 1'b0);
    send_tick(20'h55555, 1'b1);
    repeat (5) send_tick(ALL_GATES, 1'b0);
    drain();

    // Full gain drives the sum into clipping
    write_gain(GAIN_MAX);
    repeat (6) send_tick(ALL_GATES, 1'b1);
    send_tick('0, 1'b0);
    drain();

    // Zero and unit gain
    write_gain('0);
    send_tick(ALL_GATES, 1'b0);
    send_tick(20'h12345, 1'b1);
    drain();
    write_gain(15'd1);
    send_tick(ALL_GATES, 1'b1);
    send_tick(20'hEDCBA, 1'b0);
    drain();

    // Random chunks: chords held for a while, random and sparse gates mixed in
    for (c = 0; c < 6; c++) begin
      case (c)
        1:       write_gain(GAIN_MAX);
        3:       write_gain(15'd3200);
        4:       write_gain(15'($urandom_range(255)));
        default: write_gain(15'($urandom_range(32767)));
      endcase
      tx_idle_pct = (c < 2) ? 24 : (c < 4) ? 66 : 0;
      rx_idle_pct = (c < 2) ? 66 : (c < 4) ? 24 : 0;
      if (c == 4) begin
        hold_request = 1'b1;
      end
      chord = GATE_W'($urandom);
      for (int i = 0; i < CHUNK_TICKS; i++) begin
        pick = $urandom_range(99);
        if (pick < 45) begin
          gates = GATE_W'($urandom);
        end else if (pick < 80) begin
          gates = chord;
        end else if (pick < 90) begin
          gates = ALL_GATES;
        end else begin
          gates = GATE_W'(1) << $urandom_range(GATE_W - 1);
        end
        if ($urandom_range(19) == 0) begin
          chord = GATE_W'($urandom);
        end
        send_tick(gates, $urandom_range(7) == 0);
      end
      drain();
    end

    $display("Checked %0d samples under %0d gain writes (reset gain first)",
             tracker.checked, gain_writes);
    $display("Saw %0d clipped samples and %0d buffer ends", tracker.clips,
             tracker.buffer_ends);
    if (tracker.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/psg_pkg.sv
sv/psg_ctrl.sv
sv/psg_datapath.sv
sv/polyphonic_sine_tone_generator.sv
sv/psg_checker.sv
verif/tb_polyphonic_sine_tone_generator.sv
